FILE: src/gcbp_pkg.sv
// ----------------------------------------------------------------------------
// gcbp_pkg
// Types, codes and helper functions shared by the glyph column byte packer.
// ----------------------------------------------------------------------------
package gcbp_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_COLUMN = 2'd1;
   localparam logic [1:0] CMD_END    = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_DIRECTION_Y = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_SIZE = 2'd1;
   localparam logic [1:0] CSR_X_PHASE     = 2'd2;
   localparam int         CSR_DATA_W      = 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Last byte index of a single size flush (16 bytes)
   localparam logic [4:0] FLUSH_LAST_SINGLE = 5'd15;

   // Carry group lengths in Y direction
   localparam logic [2:0] GROUP_SINGLE = 3'd2;
   localparam logic [2:0] GROUP_DOUBLE = 3'd4;

   typedef enum logic [1:0] {
      OP_BEGIN,
      OP_COLUMN,
      OP_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] upper;
      logic [7:0] lower;
   } q_item_type;

   typedef struct packed {
      logic       dir_y;
      logic       dbl;
      logic [2:0] phase;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FLUSH,
      BK_SHIFT
   } back_state_type;

   // Reverse the bit order of a byte
   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

   // Double every bit of a nibble into a bit pair
   function automatic logic [7:0] widen_nibble(input logic [3:0] n);
      logic [7:0] r;
      for (int i = 0; i < 4; i++) begin
         r[2 * i]     = n[i];
         r[2 * i + 1] = n[i];
      end
      return r;
   endfunction

endpackage

FILE: src/gcbp_ifs.sv
// ----------------------------------------------------------------------------
// gcbp request and response channels
// Valid/ready channels carrying glyph columns in and framebuffer bytes out.
// ----------------------------------------------------------------------------
interface gcbp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] upper_byte;
   logic [7:0] lower_byte;

   modport source (output valid, output cmd, output upper_byte, output lower_byte,
                   input ready);
   modport sink   (input valid, input cmd, input upper_byte, input lower_byte,
                   output ready);
endinterface

interface gcbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: src/gcbp_front.sv
// ----------------------------------------------------------------------------
// gcbp_front
// Accepts request transfers, decodes the command and queues valid operations.
// ----------------------------------------------------------------------------
module gcbp_front
   import gcbp_pkg::*;
(
   gcbp_req_if.sink   req_ch,
   input  logic       q_full,
   output logic       q_push,
   output q_item_type q_item
);

   logic   keep;
   op_type op;

   // Decode the command; the unused code is accepted and dropped
   always_comb begin
      keep = 1'b1;
      op   = OP_COLUMN;
      case (req_ch.cmd)
         CMD_BEGIN:  op = OP_BEGIN;
         CMD_COLUMN: op = OP_COLUMN;
         CMD_END:    op = OP_END;
         default:    keep = 1'b0;
      endcase
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full && keep;
   assign q_item.op    = op;
   assign q_item.upper = req_ch.upper_byte;
   assign q_item.lower = req_ch.lower_byte;

endmodule

FILE: src/gcbp_queue.sv
// ----------------------------------------------------------------------------
// gcbp_queue
// Short register queue decoupling command decode from byte generation.
// ----------------------------------------------------------------------------
module gcbp_queue
   import gcbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output q_item_type head_item
);

   q_item_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff,  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not raise occupancy");

endmodule

FILE: src/gcbp_back.sv
// ----------------------------------------------------------------------------
// gcbp_back
// Executes queued operations: column transpose and flush in X direction,
// nibble widening and phase shift with carry bytes in Y direction.
// ----------------------------------------------------------------------------
module gcbp_back
   import gcbp_pkg::*;
#(
   parameter int ROW_BUFFER_BYTES = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  q_item_type  head_item,
   output logic        pop,
   gcbp_rsp_if.source  rsp_ch
);

   localparam int         DBL_CNT  = (ROW_BUFFER_BYTES < 32) ? ROW_BUFFER_BYTES : 32;
   localparam logic [4:0] DBL_LAST = 5'(DBL_CNT - 1);

   back_state_type state_ff, state_in;
   logic           lat_dir_ff, lat_dir_in;
   logic           lat_dbl_ff, lat_dbl_in;
   logic [2:0]     lat_phase_ff, lat_phase_in;
   logic [2:0]     pp_ff, pp_in;
   logic [7:0]     carry_ff, carry_in;
   logic [2:0]     gc_ff, gc_in;
   logic [15:0]    col_ff [8];
   logic [15:0]    col_in [8];
   logic [7:0]     cur_up_ff, cur_up_in;
   logic [7:0]     cur_lo_ff, cur_lo_in;
   logic [4:0]     idx_ff, idx_in;
   logic [2:0]     k_ff, k_in;
   logic           clear_after_ff, clear_after_in;
   logic           carry_pend_ff, carry_pend_in;
   logic           pend_last_ff, pend_last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           out_free;
   logic [15:0]    col_word;
   logic [2:0]     pp_next;
   logic [3:0]     gather_sel;
   logic [7:0]     gather_byte;
   logic [4:0]     flush_last;
   logic [7:0]     src_byte;
   logic [7:0]     src_half;
   logic           k_last;
   logic [15:0]    shifted;
   logic [2:0]     gc_next;
   logic [2:0]     group_len;
   logic           group_done;
   logic           byte_last;
   logic [2:0]     begin_phase;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last     = rsp_last_ff;
   assign out_free        = !rsp_valid_ff || rsp_ch.ready;

   // Column word: bit j holds the pixel for row byte j (lower rows first)
   assign col_word = {rev8(head_item.upper), rev8(head_item.lower)};
   assign pp_next  = lat_dbl_ff ? {pp_ff[2:1], 1'b0} + 3'd2 : pp_ff + 3'd1;

   // Gather a row byte from the stored columns
   assign gather_sel = lat_dbl_ff ? {idx_ff[4], idx_ff[3:1]} : idx_ff[3:0];
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         gather_byte[7 - p] = col_ff[p][gather_sel];
      end
   end
   assign flush_last = lat_dbl_ff ? DBL_LAST : FLUSH_LAST_SINGLE;

   // Select the Y source byte for step k
   assign src_half = (lat_dbl_ff ? k_ff[1] : k_ff[0]) ? cur_lo_ff : cur_up_ff;
   assign src_byte = !lat_dbl_ff ? src_half :
                     (k_ff[0] ? widen_nibble(src_half[3:0]) : widen_nibble(src_half[7:4]));
   assign k_last     = lat_dbl_ff ? (k_ff == 3'd7) : (k_ff == 3'd1);
   assign shifted    = {src_byte, 8'h00} >> lat_phase_ff;
   assign gc_next    = gc_ff + 3'd1;
   assign group_len  = lat_dbl_ff ? GROUP_DOUBLE : GROUP_SINGLE;
   assign group_done = (lat_phase_ff != 3'd0) && (gc_next == group_len);
   assign byte_last  = k_last && !group_done;

   assign begin_phase = (!cfg.dir_y && cfg.dbl) ? {cfg.phase[2:1], 1'b0} : cfg.phase;

   // Next state and outputs
   always_comb begin
      state_in       = state_ff;
      lat_dir_in     = lat_dir_ff;
      lat_dbl_in     = lat_dbl_ff;
      lat_phase_in   = lat_phase_ff;
      pp_in          = pp_ff;
      carry_in       = carry_ff;
      gc_in          = gc_ff;
      col_in         = col_ff;
      cur_up_in      = cur_up_ff;
      cur_lo_in      = cur_lo_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      clear_after_in = clear_after_ff;
      carry_pend_in  = carry_pend_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head_item.op)
                  OP_BEGIN: begin
                     lat_dir_in   = cfg.dir_y;
                     lat_dbl_in   = cfg.dbl;
                     lat_phase_in = begin_phase;
                     pp_in        = cfg.dir_y ? 3'd0 : begin_phase;
                     carry_in     = 8'h00;
                     gc_in        = 3'd0;
                     for (int p = 0; p < 8; p++) begin
                        col_in[p] = '0;
                     end
                  end
                  OP_COLUMN: begin
                     if (!lat_dir_ff) begin
                        // Transpose the column into its pixel position(s)
                        for (int p = 0; p < 8; p++) begin
                           if (lat_dbl_ff ? (3'(p) >> 1) == (pp_ff >> 1) : 3'(p) == pp_ff) begin
                              col_in[p] = col_ff[p] | col_word;
                           end
                        end
                        pp_in = pp_next;
                        if (pp_next == 3'd0) begin
                           state_in       = BK_FLUSH;
                           idx_in         = 5'd0;
                           clear_after_in = 1'b1;
                        end
                     end else begin
                        state_in      = BK_SHIFT;
                        cur_up_in     = head_item.upper;
                        cur_lo_in     = head_item.lower;
                        k_in          = 3'd0;
                        carry_pend_in = 1'b0;
                     end
                  end
                  OP_END: begin
                     if (!lat_dir_ff && pp_ff != 3'd0) begin
                        state_in       = BK_FLUSH;
                        idx_in         = 5'd0;
                        clear_after_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         BK_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = gather_byte;
               rsp_last_in  = (idx_ff == flush_last);
               idx_in       = idx_ff + 5'd1;
               if (idx_ff == flush_last) begin
                  state_in = BK_IDLE;
                  if (clear_after_ff) begin
                     for (int p = 0; p < 8; p++) begin
                        col_in[p] = '0;
                     end
                  end
               end
            end
         end

         BK_SHIFT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (carry_pend_ff) begin
                  // Drain the carry byte that closes a group
                  rsp_byte_in   = carry_ff;
                  rsp_last_in   = pend_last_ff;
                  carry_in      = 8'h00;
                  gc_in         = 3'd0;
                  carry_pend_in = 1'b0;
                  if (pend_last_ff) begin
                     state_in = BK_IDLE;
                  end
               end else begin
                  rsp_last_in = byte_last;
                  k_in        = k_ff + 3'd1;
                  if (lat_phase_ff == 3'd0) begin
                     rsp_byte_in = src_byte;
                  end else begin
                     rsp_byte_in = carry_ff | shifted[15:8];
                     carry_in    = shifted[7:0];
                     gc_in       = gc_next;
                  end
                  if (group_done) begin
                     carry_pend_in = 1'b1;
                     pend_last_in  = k_last;
                  end
                  if (byte_last) begin
                     state_in = BK_IDLE;
                  end
               end
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         lat_dir_ff    <= 1'b1;
         lat_dbl_ff    <= 1'b0;
         lat_phase_ff  <= 3'd0;
         pp_ff         <= 3'd0;
         carry_ff      <= 8'h00;
         gc_ff         <= 3'd0;
         carry_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int p = 0; p < 8; p++) begin
            col_ff[p] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         lat_dir_ff    <= lat_dir_in;
         lat_dbl_ff    <= lat_dbl_in;
         lat_phase_ff  <= lat_phase_in;
         pp_ff         <= pp_in;
         carry_ff      <= carry_in;
         gc_ff         <= gc_in;
         carry_pend_ff <= carry_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         col_ff        <= col_in;
      end
   end

   // Payload and sequencing registers
   always_ff @(posedge clock) begin
      cur_up_ff      <= cur_up_in;
      cur_lo_ff      <= cur_lo_in;
      idx_ff         <= idx_in;
      k_ff           <= k_in;
      clear_after_ff <= clear_after_in;
      pend_last_ff   <= pend_last_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   a_flush_in_x: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FLUSH) |-> !lat_dir_ff)
      else $error("row flush while in Y direction");

   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      carry_pend_ff |-> (state_ff == BK_SHIFT && lat_phase_ff != 3'd0))
      else $error("carry pending outside a shift");

   a_aligned_no_carry: assert property (@(posedge clock) disable iff (reset)
      (lat_dir_ff && lat_phase_ff == 3'd0) |-> (carry_ff == 8'h00 && gc_ff == 3'd0))
      else $error("carry state with zero phase");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      (gc_ff <= GROUP_DOUBLE) && (lat_dbl_ff || gc_ff <= GROUP_SINGLE))
      else $error("group count past its group length");

endmodule

FILE: src/glyph_column_byte_packer.sv
// ----------------------------------------------------------------------------
// glyph_column_byte_packer
// Packs 16-pixel glyph columns into display framebuffer bytes.
//
//   channel   direction  fields                           handshake
//   req_ch    in         cmd, upper_byte, lower_byte      valid/ready
//   rsp_ch    out        out_byte, last                   valid/ready
//   csr_*     in         csr_index, csr_wdata             csr_we
//
// The back end pulls one queued operation per idle cycle: begin, end
// without a flush and an X direction column are handled in the idle
// state. A row flush emits one byte a cycle while the response channel
// accepts it: 16 bytes, or up to 32 at double size. A Y direction column
// emits 2 to 3 bytes, or 8 to 10 at double size. Synchronous reset
// returns the latched setup to Y direction, single size, phase 0. A four
// entry queue keeps requests flowing while the response channel stalls.
// ----------------------------------------------------------------------------
module glyph_column_byte_packer
   import gcbp_pkg::*;
#(
   parameter int ROW_BUFFER_BYTES = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   gcbp_req_if.sink              req_ch,
   gcbp_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_full;
   logic       q_push;
   q_item_type q_item;
   logic       q_pop;
   logic       q_head_valid;
   q_item_type q_head_item;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIRECTION_Y: cfg_in.dir_y = csr_wdata[0];
            CSR_DOUBLE_SIZE: cfg_in.dbl   = csr_wdata[0];
            CSR_X_PHASE:     cfg_in.phase = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dir_y <= 1'b1;
         cfg_ff.dbl   <= 1'b0;
         cfg_ff.phase <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcbp_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_item)
   );

   gcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   gcbp_back #(
      .ROW_BUFFER_BYTES (ROW_BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
